### rtl/mvss_pkg.sv
// Shared types, constants and the segment decode for the millivolt scanner.
// No dependencies; used by every module under rtl/.
package mvss_pkg;

    localparam int ADC_W   = 12;
    localparam int MV_W    = 12;
    localparam int PROD_W  = 24;
    localparam int DIG_W   = 4;
    localparam int SEG_W   = 7;
    localparam int NDIG    = 4;
    localparam int IDX_W   = 2;

    localparam logic [11:0] SCALE_MUL = 12'd3300;
    localparam logic [12:0] ADC_FULL  = 13'd4095;
    localparam logic [MV_W-1:0] MV_MAX = 12'd3300;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [IDX_W-1:0] POS_THOU = 2'd0;
    localparam logic [IDX_W-1:0] POS_HUND = 2'd1;
    localparam logic [IDX_W-1:0] POS_TENS = 2'd2;
    localparam logic [IDX_W-1:0] POS_ONES = 2'd3;

    typedef struct packed {
        logic [DIG_W-1:0] thou;
        logic [DIG_W-1:0] hund;
        logic [DIG_W-1:0] tens;
        logic [DIG_W-1:0] ones;
    } digits_t;

    // a..g in bits 0..6; anything above nine is blank
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIG_W-1:0] d);
        logic [SEG_W-1:0] p;
        case (d)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

endpackage

### rtl/millivolt_seven_segment_scanner_core.sv
// Top level of the millivolt seven-segment scanner.
// Depends on mvss_pkg, mvss_scale, mvss_digits, mvss_drive.
//
// Each input word is either a scan tick (operation 0) or a 12-bit ADC sample
// (operation 1); every word returns exactly one output word carrying the
// current segment, common-line and decimal-point drive. A sample is scaled to
// floor(sample*3300/4095) mV and split into four decimal digits; a tick steps
// the digit index (0..3, thousands first) and latches that digit's pattern.
// One word is accepted per clock while the pipeline is not stalled. Results
// pass through the six-register pipeline (multiply, divide correction, three
// digit-split stages, output register). Stalls on m_ready back up through the
// pipeline; bubbles inside it still let input words in.
module millivolt_seven_segment_scanner_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [mvss_pkg::ADC_W-1:0]    s_adc_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mvss_pkg::SEG_W-1:0]    m_segments,
    output logic [mvss_pkg::NDIG-1:0]     m_digit_enable_n,
    output logic                          m_decimal_point
);

    logic                          sc_valid, sc_ready, sc_op;
    logic [mvss_pkg::MV_W-1:0]     sc_mv;
    logic                          dg_valid, dg_ready, dg_op;
    mvss_pkg::digits_t             dg_digits;

    mvss_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_op     (s_operation),
        .in_sample (s_adc_sample),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_op    (sc_op),
        .out_mv    (sc_mv)
    );

    mvss_digits u_digits (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (sc_valid),
        .in_ready   (sc_ready),
        .in_op      (sc_op),
        .in_mv      (sc_mv),
        .out_valid  (dg_valid),
        .out_ready  (dg_ready),
        .out_op     (dg_op),
        .out_digits (dg_digits)
    );

    mvss_drive u_drive (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (dg_valid),
        .in_ready         (dg_ready),
        .in_op            (dg_op),
        .in_digits        (dg_digits),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_segments       (m_segments),
        .m_digit_enable_n (m_digit_enable_n),
        .m_decimal_point  (m_decimal_point)
    );

    a_one_common: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(m_digit_enable_n) >= 3)
        else $error("more than one common line active");

    a_point_thou: assert property (@(posedge aclk) disable iff (!aresetn)
        m_decimal_point == (m_digit_enable_n == 4'b1110))
        else $error("decimal point not tied to thousands digit");

    a_mv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sc_valid |-> sc_mv <= mvss_pkg::MV_MAX)
        else $error("scaled value above full scale");

    a_no_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_digit_enable_n != 4'hF |-> m_segments != 7'h00)
        else $error("active digit blanked");

endmodule

### rtl/mvss_scale.sv
// Two-stage scaler: sample * 3300, then exact floor divide by 4095.
// Depends on mvss_pkg.
module mvss_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  logic [mvss_pkg::ADC_W-1:0]    in_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_op,
    output logic [mvss_pkg::MV_W-1:0]     out_mv
);

    logic                          v1_reg, v2_reg;
    logic                          op1_reg, op2_reg;
    logic [mvss_pkg::PROD_W-1:0]   prod1_reg, prod1_next;
    logic [mvss_pkg::MV_W-1:0]     mv2_reg, mv2_next;
    logic                          en1, en2;
    logic [mvss_pkg::MV_W-1:0]     q0;
    logic [12:0]                   rem;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign prod1_next = mvss_pkg::PROD_W'(in_sample) * mvss_pkg::PROD_W'(mvss_pkg::SCALE_MUL);

    // x/4095: q0 = x>>12, remainder x - 4095*q0 stays below 2*4095
    assign q0  = prod1_reg[mvss_pkg::PROD_W-1:12];
    assign rem = {1'b0, prod1_reg[11:0]} + {1'b0, q0};
    assign mv2_next = (rem >= mvss_pkg::ADC_FULL) ? q0 + 12'd1 : q0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg   <= in_op;
            prod1_reg <= prod1_next;
        end
        if (en2) begin
            op2_reg <= op1_reg;
            mv2_reg <= mv2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_op    = op2_reg;
    assign out_mv    = mv2_reg;

endmodule

### rtl/mvss_digits.sv
// Three-stage decimal split of the millivolt value into four digits.
// Depends on mvss_pkg.
module mvss_digits (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  logic [mvss_pkg::MV_W-1:0]     in_mv,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_op,
    output mvss_pkg::digits_t             out_digits
);

    logic v3_reg, v4_reg, v5_reg;
    logic op3_reg, op4_reg, op5_reg;
    logic en3, en4, en5;

    logic [1:0]  thou3_reg, thou3_next, thou4_reg;
    logic [9:0]  r1_reg, r1_next;
    logic [3:0]  hund4_reg, hund4_next;
    logic [6:0]  r2_reg, r2_next;
    logic [15:0] hprod;
    logic [14:0] tprod;
    logic [3:0]  tens_next, ones_next;
    mvss_pkg::digits_t dig5_reg, dig5_next;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    always_comb begin
        if (in_mv >= 12'd3000)      thou3_next = 2'd3;
        else if (in_mv >= 12'd2000) thou3_next = 2'd2;
        else if (in_mv >= 12'd1000) thou3_next = 2'd1;
        else                        thou3_next = 2'd0;
        r1_next = 10'(in_mv - 12'(thou3_next) * 12'd1000);
    end

    // r1 < 1000: (r1*41)>>12 == r1/100
    assign hprod      = 16'(r1_reg) * 16'd41;
    assign hund4_next = hprod[15:12];
    assign r2_next    = 7'(r1_reg - 10'(hund4_next) * 10'd100);

    // r2 < 100: (r2*205)>>11 == r2/10
    assign tprod     = 15'(r2_reg) * 15'd205;
    assign tens_next = tprod[14:11];
    assign ones_next = 4'(r2_reg - 7'(tens_next) * 7'd10);

    always_comb begin
        dig5_next.thou = {2'b00, thou4_reg};
        dig5_next.hund = hund4_reg;
        dig5_next.tens = tens_next;
        dig5_next.ones = ones_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en3) v3_reg <= in_valid;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            op3_reg   <= in_op;
            thou3_reg <= thou3_next;
            r1_reg    <= r1_next;
        end
        if (en4) begin
            op4_reg   <= op3_reg;
            thou4_reg <= thou3_reg;
            hund4_reg <= hund4_next;
            r2_reg    <= r2_next;
        end
        if (en5) begin
            op5_reg  <= op4_reg;
            dig5_reg <= dig5_next;
        end
    end

    assign out_valid  = v5_reg;
    assign out_op     = op5_reg;
    assign out_digits = dig5_reg;

endmodule

### rtl/mvss_drive.sv
// Display state and output register: stored digits, scan index, latched drive.
// Depends on mvss_pkg.
module mvss_drive (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  mvss_pkg::digits_t             in_digits,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mvss_pkg::SEG_W-1:0]    m_segments,
    output logic [mvss_pkg::NDIG-1:0]     m_digit_enable_n,
    output logic                          m_decimal_point
);

    logic                          valid_reg;
    mvss_pkg::digits_t             digits_reg;
    logic [mvss_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [mvss_pkg::SEG_W-1:0]    seg_reg, seg_next;
    logic [mvss_pkg::NDIG-1:0]     com_reg, com_next;
    logic                          pt_reg, pt_next;
    logic [mvss_pkg::DIG_W-1:0]    sel_digit;
    logic                          take;

    assign in_ready = !valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    assign idx_next = idx_reg + 2'd1;

    always_comb begin
        case (idx_next)
            mvss_pkg::POS_THOU: sel_digit = digits_reg.thou;
            mvss_pkg::POS_HUND: sel_digit = digits_reg.hund;
            mvss_pkg::POS_TENS: sel_digit = digits_reg.tens;
            mvss_pkg::POS_ONES: sel_digit = digits_reg.ones;
            default:            sel_digit = digits_reg.ones;
        endcase
        seg_next = mvss_pkg::seg_pattern(sel_digit);
        com_next = ~(4'b0001 << idx_next);
        pt_next  = (idx_next == mvss_pkg::POS_THOU);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            digits_reg <= '0;
            idx_reg    <= '0;
            seg_reg    <= '0;
            com_reg    <= '1;
            pt_reg     <= 1'b0;
        end else begin
            if (in_ready) valid_reg <= in_valid;
            if (take) begin
                if (in_op == mvss_pkg::OP_SAMPLE) begin
                    digits_reg <= in_digits;
                end else begin
                    idx_reg <= idx_next;
                    seg_reg <= seg_next;
                    com_reg <= com_next;
                    pt_reg  <= pt_next;
                end
            end
        end
    end

    assign m_valid          = valid_reg;
    assign m_segments       = seg_reg;
    assign m_digit_enable_n = com_reg;
    assign m_decimal_point  = pt_reg;

endmodule
